/* hdl/ipc_pkg.sv */
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared constants and the token type that travels down the comparator chain
// of the inversion pair counter.
// ----------------------------------------------------------------------------
package ipc_pkg;

   localparam int MAX_ITEMS  = 1024;
   localparam int VALUE_BITS = 32;

   // result field widths and their saturation limits
   localparam int INV_W    = 19;
   localparam int ELEM_W   = 11;
   localparam int INV_MAX  = (1 << INV_W) - 1;
   localparam int ELEM_MAX = (1 << ELEM_W) - 1;

   // per-transaction count of greater elements, and per-sequence counters
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int TOT_W = 2 * $clog2(MAX_ITEMS);

   localparam int INV_CMP_W  = (TOT_W > INV_W) ? TOT_W : INV_W;
   localparam int ELEM_CMP_W = (CNT_W > ELEM_W) ? CNT_W : ELEM_W;

   typedef struct packed {
      logic                  vld;
      logic                  last;
      logic                  placed;   // found a free cell on its way
      logic [VALUE_BITS-1:0] value;
      logic [CNT_W-1:0]      greater;  // stored elements greater than value
   } token_type;

endpackage

/* hdl/inversion_pair_counter.sv */
// ----------------------------------------------------------------------------
// inversion_pair_counter
// Counts the pairs of a signed sequence whose earlier element is greater.
// ----------------------------------------------------------------------------
// Elements enter a chain of MAX_ITEMS comparator cells, one transaction per
// clock cycle unless a finished result is waiting under a stall. Each element
// walks the chain one cell per cycle, counting the stored elements greater
// than itself, and settles in the first free cell; an element that finds no
// free cell is dropped and marks the sequence as overflowed. The final element
// of a sequence empties the cells behind it, so the next sequence may follow
// in the very next cycle. The result is registered at the end of the chain
// once the final element has walked through every cell of it. A waiting
// result that is stalled holds the whole chain.
// ----------------------------------------------------------------------------
module inversion_pair_counter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ipc_pkg::VALUE_BITS-1:0]   req_value,
   input  logic                             req_last,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ipc_pkg::INV_W-1:0]        rsp_inversion_count,
   output logic [ipc_pkg::ELEM_W-1:0]       rsp_element_count,
   output logic                             rsp_overflowed
);
   import ipc_pkg::*;

   token_type chain [0:MAX_ITEMS];
   logic      advance;

   assign req_stall = !advance;

   always_comb begin
      chain[0].vld     = req_valid;
      chain[0].last    = req_last;
      chain[0].placed  = 1'b0;
      chain[0].value   = req_value;
      chain[0].greater = '0;
   end

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      ipc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_tok  (chain[i]),
         .dn_tok  (chain[i+1])
      );
   end

   ipc_tally u_tally (
      .clock               (clock),
      .reset               (reset),
      .tail_tok            (chain[MAX_ITEMS]),
      .advance             (advance),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_inversion_count (rsp_inversion_count),
      .rsp_element_count   (rsp_element_count),
      .rsp_overflowed      (rsp_overflowed)
   );

endmodule

/* hdl/ipc_cell.sv */
// ----------------------------------------------------------------------------
// ipc_cell
// One cell of the comparator chain: holds one stored element, compares the
// passing token against it and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module ipc_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  ipc_pkg::token_type up_tok,
   output ipc_pkg::token_type dn_tok
);
   import ipc_pkg::*;

   token_type             tok_ff;
   token_type             tok_in;
   logic [VALUE_BITS-1:0] held_ff;
   logic [VALUE_BITS-1:0] held_in;
   logic                  held_vld_ff;
   logic                  held_vld_in;

   always_comb begin
      tok_in      = up_tok;
      held_in     = held_ff;
      held_vld_in = held_vld_ff;
      if (up_tok.vld) begin
         if (held_vld_ff) begin
            if ($signed(held_ff) > $signed(up_tok.value)) begin
               tok_in.greater = up_tok.greater + CNT_W'(1);
            end
            // the end of a sequence empties every cell it passes
            if (up_tok.last) begin
               held_vld_in = 1'b0;
            end
         end else if (!up_tok.placed) begin
            // first free cell: this is the element's slot
            tok_in.placed = 1'b1;
            if (!up_tok.last) begin
               held_in     = up_tok.value;
               held_vld_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.vld  <= 1'b0;
         held_vld_ff <= 1'b0;
      end else if (advance) begin
         tok_ff      <= tok_in;
         held_vld_ff <= held_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         held_ff <= held_in;
      end
   end

   assign dn_tok = tok_ff;

endmodule

/* hdl/ipc_tally.sv */
// ----------------------------------------------------------------------------
// ipc_tally
// End of the chain: accumulates the per-sequence totals from the tokens that
// leave the last cell and holds the result transaction until it is taken.
// ----------------------------------------------------------------------------
module ipc_tally (
   input  logic                         clock,
   input  logic                         reset,
   input  ipc_pkg::token_type           tail_tok,
   output logic                         advance,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ipc_pkg::INV_W-1:0]    rsp_inversion_count,
   output logic [ipc_pkg::ELEM_W-1:0]   rsp_element_count,
   output logic                         rsp_overflowed
);
   import ipc_pkg::*;

   logic [TOT_W-1:0]      total_ff;
   logic [TOT_W-1:0]      total_in;
   logic [CNT_W-1:0]      elem_ff;
   logic [CNT_W-1:0]      elem_in;
   logic                  ovf_ff;
   logic                  ovf_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [INV_W-1:0]      rsp_inv_ff;
   logic [INV_W-1:0]      rsp_inv_in;
   logic [ELEM_W-1:0]     rsp_elem_ff;
   logic [ELEM_W-1:0]     rsp_elem_in;
   logic                  rsp_ovf_ff;
   logic                  rsp_ovf_in;
   logic [TOT_W-1:0]      total_sum;
   logic [CNT_W-1:0]      elem_sum;
   logic                  ovf_any;
   logic [INV_CMP_W-1:0]  total_ext;
   logic [ELEM_CMP_W-1:0] elem_ext;

   // hold the whole chain while a finished result waits
   assign advance = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      total_sum = total_ff;
      elem_sum  = elem_ff;
      ovf_any   = ovf_ff;
      if (tail_tok.placed) begin
         total_sum = total_ff + TOT_W'(tail_tok.greater);
         elem_sum  = elem_ff + CNT_W'(1);
      end else begin
         ovf_any = 1'b1;
      end
      total_ext = INV_CMP_W'(total_sum);
      elem_ext  = ELEM_CMP_W'(elem_sum);

      total_in     = total_ff;
      elem_in      = elem_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_inv_in   = rsp_inv_ff;
      rsp_elem_in  = rsp_elem_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (advance && tail_tok.vld) begin
         if (tail_tok.last) begin
            rsp_valid_in = 1'b1;
            rsp_inv_in   = (total_ext > INV_CMP_W'(INV_MAX)) ? INV_W'(INV_MAX)
                                                             : INV_W'(total_ext);
            rsp_elem_in  = (elem_ext > ELEM_CMP_W'(ELEM_MAX)) ? ELEM_W'(ELEM_MAX)
                                                              : ELEM_W'(elem_ext);
            rsp_ovf_in   = ovf_any;
            // start the next sequence from zero
            total_in     = '0;
            elem_in      = '0;
            ovf_in       = 1'b0;
         end else begin
            total_in = total_sum;
            elem_in  = elem_sum;
            ovf_in   = ovf_any;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         elem_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         elem_ff      <= elem_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_inv_ff  <= rsp_inv_in;
      rsp_elem_ff <= rsp_elem_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_inversion_count = rsp_inv_ff;
   assign rsp_element_count   = rsp_elem_ff;
   assign rsp_overflowed      = rsp_ovf_ff;

endmodule
